@@ hw/rtl/ptc_pkg.sv @@
`default_nettype none
package ptc_pkg;

    localparam int ENTRIES      = 64;
    localparam int COUNTER_BITS = 32;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int I_W          = (IDX_W > 5) ? IDX_W : 5;
    localparam int CMP_W        = ((IDX_W > 7) ? IDX_W : 7) + 2;
    localparam int ITEMS        = 32;
    localparam int ITEM_W       = 5;

    localparam logic [5:0]  SEL_MAC   = 6'd32;
    localparam logic [5:0]  SEL_IP    = 6'd33;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_ARP   = 16'h0806;
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_SRD,
        S_SCMP,
        S_BWR,
        S_INS,
        S_BCCHK,
        S_BCWR,
        S_NEXT,
        S_RADDR,
        S_ROUT
    } ptc_state_t;

    typedef struct packed {
        logic cap_en;
        logic cap_clear;
        logic cls_load;
        logic dst;
        logic i_clr;
        logic i_inc;
        logic rd_latch;
        logic rd_mode;
        logic bump_wr;
        logic sweep_wr;
        logic used_inc;
        logic out_load;
    } ptc_cmd_t;

    typedef struct packed {
        logic             eth_ok;
        logic             pos_ge13;
        logic             i_lt_used;
        logic             match;
        logic             bcast;
        logic             full;
        logic             i_last;
        logic             out_free;
        logic [IDX_W-1:0] used;
    } ptc_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/ptc_if.sv @@
`default_nettype none
interface ptc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [6:0] entry_index;
    logic [5:0] item_select;

    modport source (output valid, command, frame_byte, frame_last, entry_index, item_select,
                    input ready);
    modport sink (input valid, command, frame_byte, frame_last, entry_index, item_select,
                  output ready);
endinterface

interface ptc_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] read_data;
    logic        entry_valid;
    logic [5:0]  entry_count;

    modport source (output valid, read_data, entry_valid, entry_count, input ready);
    modport sink (input valid, read_data, entry_valid, entry_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ptc_ctrl.sv @@
`default_nettype none
module ptc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    input  wire logic              command,
    input  wire logic              frame_last,
    output logic                   ready,
    output ptc_pkg::ptc_cmd_t      cmd,
    input  wire ptc_pkg::ptc_sts_t sts
);

    ptc_pkg::ptc_state_t state_reg, state_next;
    logic                phase_reg, phase_next;
    logic                acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptc_pkg::S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.dst    = phase_reg;
        ready      = (state_reg == ptc_pkg::S_IDLE);
        acc        = valid && ready;
        case (state_reg)
            ptc_pkg::S_IDLE:
            begin
                if (acc && !command)
                begin
                    cmd.cap_en = 1'b1;
                    if (frame_last)
                    begin
                        if (sts.pos_ge13)
                            state_next = ptc_pkg::S_CLASS;
                        else
                            cmd.cap_clear = 1'b1;
                    end
                end
                else if (acc)
                begin
                    cmd.rd_latch = 1'b1;
                    state_next   = ptc_pkg::S_RADDR;
                end
            end
            ptc_pkg::S_CLASS:
            begin
                if (!sts.eth_ok)
                begin
                    cmd.cap_clear = 1'b1;
                    state_next    = ptc_pkg::S_IDLE;
                end
                else
                begin
                    cmd.cls_load = 1'b1;
                    cmd.i_clr    = 1'b1;
                    phase_next   = 1'b0;
                    state_next   = ptc_pkg::S_SRD;
                end
            end
            ptc_pkg::S_SRD:
            begin
                if (sts.i_lt_used)
                    state_next = ptc_pkg::S_SCMP;
                else if (sts.full)
                    state_next = ptc_pkg::S_NEXT;
                else
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = ptc_pkg::S_INS;
                end
            end
            ptc_pkg::S_SCMP:
            begin
                if (sts.match && phase_reg && sts.bcast)
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = ptc_pkg::S_BCCHK;
                end
                else if (sts.match)
                    state_next = ptc_pkg::S_BWR;
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ptc_pkg::S_SRD;
                end
            end
            ptc_pkg::S_BWR:
            begin
                cmd.bump_wr = 1'b1;
                state_next  = ptc_pkg::S_NEXT;
            end
            ptc_pkg::S_INS:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.i_last)
                begin
                    cmd.used_inc = 1'b1;
                    state_next   = ptc_pkg::S_NEXT;
                end
                else
                    cmd.i_inc = 1'b1;
            end
            ptc_pkg::S_BCCHK:
            begin
                if (sts.i_lt_used)
                    state_next = ptc_pkg::S_BCWR;
                else
                    state_next = ptc_pkg::S_NEXT;
            end
            ptc_pkg::S_BCWR:
            begin
                cmd.bump_wr = 1'b1;
                cmd.i_inc   = 1'b1;
                state_next  = ptc_pkg::S_BCCHK;
            end
            ptc_pkg::S_NEXT:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    cmd.i_clr  = 1'b1;
                    state_next = ptc_pkg::S_SRD;
                end
                else
                begin
                    phase_next    = 1'b0;
                    cmd.cap_clear = 1'b1;
                    state_next    = ptc_pkg::S_IDLE;
                end
            end
            ptc_pkg::S_RADDR:
            begin
                cmd.rd_mode = 1'b1;
                state_next  = ptc_pkg::S_ROUT;
            end
            ptc_pkg::S_ROUT:
            begin
                cmd.rd_mode = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ptc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/ptc_dp.sv @@
`default_nettype none
module ptc_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        frame_byte,
    input  wire logic [6:0]        entry_index,
    input  wire logic [5:0]        item_select,
    input  wire ptc_pkg::ptc_cmd_t cmd,
    output ptc_pkg::ptc_sts_t      sts,
    ptc_out_if.source              results
);

    localparam int IDX_W = ptc_pkg::IDX_W;
    localparam int I_W   = ptc_pkg::I_W;
    localparam int CMP_W = ptc_pkg::CMP_W;
    localparam int CNT_W = ptc_pkg::COUNTER_BITS;
    localparam int IW    = ptc_pkg::ITEM_W;

    localparam logic [3:0] CAT_ARP      = 4'd0;
    localparam logic [3:0] CAT_ICMP     = 4'd1;
    localparam logic [3:0] CAT_IGMP     = 4'd2;
    localparam logic [3:0] CAT_IP_OTHER = 4'd3;
    localparam logic [3:0] CAT_HTTP     = 4'd4;
    localparam logic [3:0] CAT_HTTPS    = 4'd5;
    localparam logic [3:0] CAT_TCP_IMAP = 4'd6;
    localparam logic [3:0] CAT_SMTP     = 4'd7;
    localparam logic [3:0] CAT_TCP_SSH  = 4'd8;
    localparam logic [3:0] CAT_TCP_OTH  = 4'd9;
    localparam logic [3:0] CAT_DHCP_CL  = 4'd10;
    localparam logic [3:0] CAT_DHCP_SV  = 4'd11;
    localparam logic [3:0] CAT_UDP_IMAP = 4'd12;
    localparam logic [3:0] CAT_UDP_SSH  = 4'd13;
    localparam logic [3:0] CAT_TFTP     = 4'd14;
    localparam logic [3:0] CAT_UDP_OTH  = 4'd15;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    function automatic logic [3:0] port_cat(input logic [15:0] port, input logic tcp);
        logic [3:0] c;
        case (port)
            16'd68:  c = CAT_DHCP_CL;
            16'd67:  c = CAT_DHCP_SV;
            16'd80:  c = CAT_HTTP;
            16'd443: c = CAT_HTTPS;
            16'd143: c = tcp ? CAT_TCP_IMAP : CAT_UDP_IMAP;
            16'd25:  c = CAT_SMTP;
            16'd22:  c = tcp ? CAT_TCP_SSH : CAT_UDP_SSH;
            16'd69:  c = CAT_TFTP;
            default: c = tcp ? CAT_TCP_OTH : CAT_UDP_OTH;
        endcase
        return c;
    endfunction

    // frame capture
    logic [6:0]  pos_reg;
    logic [47:0] dmac_reg, smac_reg;
    logic [15:0] eth_reg, psrc_reg, pdst_reg;
    logic [3:0]  ihl_reg;
    logic [7:0]  proto_reg;
    logic [63:0] ip_reg;
    logic [7:0]  port_start;
    logic [7:0]  pos8;
    logic [7:0]  port_k;
    logic        in_port;

    assign pos8       = {1'b0, pos_reg};
    assign port_start = 8'd14 + {2'b00, ihl_reg, 2'b00};
    assign port_k     = pos8 - port_start;
    assign in_port    = (ihl_reg >= 4'd3) && (pos8 >= port_start)
                        && (pos8 < port_start + 8'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            dmac_reg  <= '0;
            smac_reg  <= '0;
            eth_reg   <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            psrc_reg  <= '0;
            pdst_reg  <= '0;
            ip_reg    <= '0;
        end
        else if (cmd.cap_clear)
        begin
            pos_reg   <= '0;
            dmac_reg  <= '0;
            smac_reg  <= '0;
            eth_reg   <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            psrc_reg  <= '0;
            pdst_reg  <= '0;
            ip_reg    <= '0;
        end
        else if (cmd.cap_en)
        begin
            if (pos_reg < 7'd6)
                dmac_reg <= {dmac_reg[39:0], frame_byte};
            else if (pos_reg < 7'd12)
                smac_reg <= {smac_reg[39:0], frame_byte};
            else if (pos_reg == 7'd12)
                eth_reg[15:8] <= frame_byte;
            else if (pos_reg == 7'd13)
                eth_reg[7:0] <= frame_byte;
            else if (pos_reg == 7'd14)
                ihl_reg <= frame_byte[3:0];
            else if (pos_reg == 7'd23)
                proto_reg <= frame_byte;
            if (pos_reg >= 7'd26 && pos_reg < 7'd34)
                ip_reg <= {ip_reg[55:0], frame_byte};
            if (in_port)
            begin
                if (port_k < 8'd2)
                    psrc_reg <= {psrc_reg[7:0], frame_byte};
                else
                    pdst_reg <= {pdst_reg[7:0], frame_byte};
            end
            if (pos_reg != 7'd127)
                pos_reg <= pos_reg + 7'd1;
        end
    end

    // classification
    logic [3:0] s_c, r_c;
    logic       sdef_c, ipv4_c, tcp_c;

    always_comb
    begin
        s_c    = CAT_ARP;
        r_c    = CAT_ARP;
        sdef_c = 1'b0;
        ipv4_c = (eth_reg == ptc_pkg::ETH_IPV4);
        tcp_c  = (proto_reg == PROTO_TCP);
        if (ipv4_c)
        begin
            if (proto_reg == PROTO_ICMP)
            begin
                s_c = CAT_ICMP;
                r_c = CAT_ICMP;
            end
            else if (proto_reg == PROTO_IGMP)
            begin
                s_c = CAT_IGMP;
                r_c = CAT_IGMP;
            end
            else if (tcp_c || proto_reg == PROTO_UDP)
            begin
                s_c    = port_cat(psrc_reg, tcp_c);
                r_c    = port_cat(pdst_reg, tcp_c);
                sdef_c = (s_c == CAT_TCP_OTH) || (s_c == CAT_UDP_OTH);
            end
            else
            begin
                s_c = CAT_IP_OTHER;
                r_c = CAT_IP_OTHER;
            end
        end
    end

    logic [3:0]       s_reg, r_reg;
    logic             ipv4_reg;
    logic [CNT_W-1:0] totals_reg [ptc_pkg::ITEMS];
    logic [I_W-1:0]   i_reg;
    logic [IDX_W-1:0] used_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cls_load)
        begin
            s_reg    <= s_c;
            r_reg    <= r_c;
            ipv4_reg <= ipv4_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ptc_pkg::ITEMS; k++)
                totals_reg[k] <= '0;
            i_reg    <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (cmd.cls_load)
            begin
                totals_reg[{1'b1, r_c}] <= totals_reg[{1'b1, r_c}] + CNT_W'(1);
                if (sdef_c)
                    totals_reg[{1'b0, s_c}] <= totals_reg[{1'b0, s_c}] + CNT_W'(1);
            end
            if (cmd.i_clr)
                i_reg <= '0;
            else if (cmd.i_inc)
                i_reg <= i_reg + I_W'(1);
            if (cmd.used_inc)
                used_reg <= used_reg + IDX_W'(1);
        end
    end

    // tables
    logic [47:0]      tmac;
    logic [IW-1:0]    slot;
    logic [31:0]      ins_ip;
    logic [6:0]       ridx_reg;
    logic [5:0]       ritem_reg;
    logic [IDX_W+6:0] ridx_ext;
    logic [IDX_W-1:0] tab_addr;
    logic [IDX_W+IW-1:0] cnt_raddr, cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;
    logic [47:0]      mac_rd;
    logic [31:0]      ip_rd;
    logic [CNT_W-1:0] cnt_rd;

    logic [47:0]      mac_mem [ptc_pkg::ENTRIES];
    logic [31:0]      ip_mem  [ptc_pkg::ENTRIES];
    logic [CNT_W-1:0] cnt_mem [ptc_pkg::ENTRIES * ptc_pkg::ITEMS];

    assign tmac     = cmd.dst ? dmac_reg : smac_reg;
    assign slot     = cmd.dst ? {1'b1, r_reg} : {1'b0, s_reg};
    assign ins_ip   = !ipv4_reg ? 32'd0 : (cmd.dst ? ip_reg[31:0] : ip_reg[63:32]);
    assign ridx_ext = {{IDX_W{1'b0}}, ridx_reg};
    assign tab_addr = cmd.rd_mode ? ridx_ext[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign cnt_raddr = cmd.rd_mode ? {ridx_ext[IDX_W-1:0], ritem_reg[IW-1:0]}
                                   : {i_reg[IDX_W-1:0], slot};
    assign cnt_waddr = cmd.sweep_wr ? {used_reg, i_reg[IW-1:0]} : {i_reg[IDX_W-1:0], slot};
    assign cnt_wdata = cmd.sweep_wr ? CNT_W'(i_reg[IW-1:0] == slot) : cnt_rd + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_latch)
        begin
            ridx_reg  <= entry_index;
            ritem_reg <= item_select;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr)
        begin
            mac_mem[used_reg] <= tmac;
            ip_mem[used_reg]  <= ins_ip;
        end
        mac_rd <= mac_mem[tab_addr];
        ip_rd  <= ip_mem[tab_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr || cmd.bump_wr)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd <= cnt_mem[cnt_raddr];
    end

    // read result
    logic [CMP_W-1:0] ridx_cmp, used_cmp, i_cmp;
    logic             is_tab, is_tot;
    logic [47:0]      rdata_c;
    logic             out_valid_reg;
    logic [47:0]      out_data_reg;
    logic             out_ev_reg;
    logic [5:0]       out_cnt_reg;

    assign ridx_cmp = CMP_W'(ridx_reg);
    assign used_cmp = CMP_W'(used_reg);
    assign i_cmp    = CMP_W'(i_reg);
    assign is_tab   = ridx_cmp < used_cmp;
    assign is_tot   = ridx_cmp == CMP_W'(ptc_pkg::ENTRIES);

    always_comb
    begin
        rdata_c = '0;
        if (is_tab)
        begin
            if (!ritem_reg[5])
                rdata_c = 48'(cnt_rd);
            else if (ritem_reg == ptc_pkg::SEL_MAC)
                rdata_c = mac_rd;
            else if (ritem_reg == ptc_pkg::SEL_IP)
                rdata_c = {16'd0, ip_rd};
        end
        else if (is_tot && !ritem_reg[5])
            rdata_c = 48'(totals_reg[ritem_reg[IW-1:0]]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= rdata_c;
            out_ev_reg   <= is_tab || is_tot;
            out_cnt_reg  <= 6'(used_reg);
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.read_data   = out_data_reg;
    assign results.entry_valid = out_ev_reg;
    assign results.entry_count = out_cnt_reg;

    assign sts.eth_ok    = (eth_reg == ptc_pkg::ETH_IPV4) || (eth_reg == ptc_pkg::ETH_ARP);
    assign sts.pos_ge13  = pos_reg >= 7'd13;
    assign sts.i_lt_used = i_cmp < used_cmp;
    assign sts.match     = mac_rd == tmac;
    assign sts.bcast     = dmac_reg == ptc_pkg::BCAST_MAC;
    assign sts.full      = used_cmp >= CMP_W'(ptc_pkg::ENTRIES - 1);
    assign sts.i_last    = i_reg[IW-1:0] == IW'(ptc_pkg::ITEMS - 1);
    assign sts.out_free  = !out_valid_reg || results.ready;
    assign sts.used      = used_reg;

endmodule
`default_nettype wire

@@ hw/rtl/per_mac_traffic_classifier.sv @@
// frame bytes: one word per cycle, no result
// read word: result registered in S_ROUT once output free, next word taken the cycle after
// last frame byte: input held for the table walk (S_SRD, S_SCMP per entry, on each side),
//   plus an insert (counter row sweep) or S_BCCHK, S_BCWR per entry for a broadcast credit
// reset (async, active low) clears capture, totals and entry count; tables are not cleared
`default_nettype none
module per_mac_traffic_classifier (
    input  wire logic clk,
    input  wire logic rst_n,
    ptc_in_if.sink    items,
    ptc_out_if.source results
);

    ptc_pkg::ptc_cmd_t cmd;
    ptc_pkg::ptc_sts_t sts;
    logic              ready;

    assign items.ready = ready;

    ptc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (items.valid),
        .command    (items.command),
        .frame_last (items.frame_last),
        .ready      (ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    ptc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_byte  (items.frame_byte),
        .entry_index (items.entry_index),
        .item_select (items.item_select),
        .cmd         (cmd),
        .sts         (sts),
        .results     (results)
    );

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sts.used) <= ptc_pkg::ENTRIES - 1)
        else $error("entry count beyond table limit");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready |-> !cmd.bump_wr && !cmd.sweep_wr)
        else $error("table write while taking words");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.used_inc |-> !sts.full)
        else $error("insert into full table");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !results.valid || results.ready)
        else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

@@ verif/ptc_tb_if.sv @@
`timescale 1ns / 100ps
// the interfaces come from the rtl file hw/rtl/ptc_if.sv; nothing to add here
package ptc_tb_pkg;
    import ptc_pkg::*;

    // counter categories
    typedef enum int {
        CAT_ARP, CAT_ICMP, CAT_IGMP, CAT_IP_OTHER, CAT_HTTP, CAT_HTTPS, CAT_TCP_IMAP,
        CAT_SMTP, CAT_TCP_SSH, CAT_TCP_OTHER, CAT_DHCP_CLIENT, CAT_DHCP_SERVER,
        CAT_UDP_IMAP, CAT_UDP_SSH, CAT_TFTP, CAT_UDP_OTHER
    } traffic_cat_t;

    localparam bit CMD_BYTE = 1'b0;
    localparam bit CMD_READ = 1'b1;
    localparam int RX_BASE  = 16;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef struct packed {
        logic [47:0] read_data;
        logic        entry_valid;
        logic [5:0]  entry_count;
    } read_word_t;
endpackage

@@ verif/tb_per_mac_traffic_classifier.sv @@
`timescale 1ns / 100ps
module tb_per_mac_traffic_classifier;
    import ptc_pkg::*;
    import ptc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptc_in_if  items ();
    ptc_out_if results ();

    per_mac_traffic_classifier i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the statistics block
    logic [7:0]  pos_q;
    logic [47:0] dst_mac_q, src_mac_q;
    logic [15:0] ethertype_q, sport_q, dport_q;
    logic [3:0]  ihl_q;
    logic [7:0]  proto_q;
    logic [63:0] ip_pair_q;
    logic [47:0] host_mac [ENTRIES];
    logic [31:0] host_ip [ENTRIES];
    logic [COUNTER_BITS-1:0] host_cnt [ENTRIES][ITEMS];
    logic [COUNTER_BITS-1:0] total_cnt [ITEMS];
    int          hosts_used;

    read_word_t  expected_reads [$];
    int          mismatches = 0;
    int          cycles = 0;

    event        hold_go;
    bit          hold_off = 1'b0;
    bit          burst_mode = 1'b1;

    task automatic clear_capture();
        pos_q = 0; dst_mac_q = 0; src_mac_q = 0; ethertype_q = 0;
        ihl_q = 0; proto_q = 0; sport_q = 0; dport_q = 0; ip_pair_q = 0;
    endtask

    function automatic int port_to_cat(logic [15:0] port, bit tcp);
        case (port)
            16'd68:  return CAT_DHCP_CLIENT;
            16'd67:  return CAT_DHCP_SERVER;
            16'd80:  return CAT_HTTP;
            16'd443: return CAT_HTTPS;
            16'd143: return tcp ? CAT_TCP_IMAP : CAT_UDP_IMAP;
            16'd25:  return CAT_SMTP;
            16'd22:  return tcp ? CAT_TCP_SSH : CAT_UDP_SSH;
            16'd69:  return CAT_TFTP;
            default: return tcp ? CAT_TCP_OTHER : CAT_UDP_OTHER;
        endcase
    endfunction

    function automatic int lookup_host(logic [47:0] mac);
        for (int i = 0; i < hosts_used; i++)
            if (host_mac[i] == mac)
                return i;
        return -1;
    endfunction

    task automatic add_host(logic [47:0] mac, logic [31:0] ip, int slot);
        if (hosts_used >= ENTRIES - 1)
            return;
        host_mac[hosts_used] = mac;
        host_ip[hosts_used] = ip;
        for (int k = 0; k < ITEMS; k++)
            host_cnt[hosts_used][k] = '0;
        host_cnt[hosts_used][slot] = 1;
        hosts_used++;
    endtask

    task automatic account_frame();
        int  s, r, p;
        bit  src_default;
        logic [31:0] sip, dip;
        src_default = 0; sip = 0; dip = 0;
        if (ethertype_q == ETH_ARP)
        begin
            s = CAT_ARP; r = CAT_ARP;
        end
        else if (ethertype_q == ETH_IPV4)
        begin
            sip = ip_pair_q[63:32];
            dip = ip_pair_q[31:0];
            if (proto_q == PROTO_ICMP)
            begin
                s = CAT_ICMP; r = CAT_ICMP;
            end
            else if (proto_q == PROTO_IGMP)
            begin
                s = CAT_IGMP; r = CAT_IGMP;
            end
            else if (proto_q == PROTO_TCP || proto_q == PROTO_UDP)
            begin
                s = port_to_cat(sport_q, proto_q == PROTO_TCP);
                r = port_to_cat(dport_q, proto_q == PROTO_TCP);
                src_default = (s == CAT_TCP_OTHER || s == CAT_UDP_OTHER);
            end
            else
            begin
                s = CAT_IP_OTHER; r = CAT_IP_OTHER;
            end
        end
        else
            return;
        total_cnt[RX_BASE + r]++;
        if (src_default)
            total_cnt[s]++;
        p = lookup_host(src_mac_q);
        if (p >= 0)
            host_cnt[p][s]++;
        else
            add_host(src_mac_q, sip, s);
        p = lookup_host(dst_mac_q);
        if (p < 0)
            add_host(dst_mac_q, dip, RX_BASE + r);
        else if (dst_mac_q == BCAST_MAC)
            for (int i = 0; i < hosts_used; i++)
                host_cnt[i][RX_BASE + r]++;
        else
            host_cnt[p][RX_BASE + r]++;
    endtask

    task automatic predict_byte(logic [7:0] b, logic last);
        int start;
        if (pos_q < 6)
            dst_mac_q = {dst_mac_q[39:0], b};
        else if (pos_q < 12)
            src_mac_q = {src_mac_q[39:0], b};
        else if (pos_q == 12)
            ethertype_q[15:8] = b;
        else if (pos_q == 13)
            ethertype_q[7:0] = b;
        else if (pos_q == 14)
            ihl_q = b[3:0];
        else if (pos_q == 23)
            proto_q = b;
        if (pos_q >= 26 && pos_q < 34)
            ip_pair_q = {ip_pair_q[55:0], b};
        if (ihl_q >= 3)
        begin
            start = 14 + 4 * ihl_q;
            if (pos_q >= start && pos_q < start + 2)
                sport_q = {sport_q[7:0], b};
            else if (pos_q >= start + 2 && pos_q < start + 4)
                dport_q = {dport_q[7:0], b};
        end
        if (last)
        begin
            if (pos_q >= 13)
                account_frame();
            clear_capture();
        end
        else if (pos_q < 127)
            pos_q++;
    endtask

    function automatic read_word_t predict_read(int idx, int sel);
        read_word_t w;
        logic [63:0] v;
        v = 0;
        w.entry_valid = 0;
        if (idx < hosts_used)
        begin
            w.entry_valid = 1;
            if (sel < ITEMS)
                v = 64'(host_cnt[idx][sel]);
            else if (sel == SEL_MAC)
                v = 64'(host_mac[idx]);
            else if (sel == SEL_IP)
                v = 64'(host_ip[idx]);
        end
        else if (idx == ENTRIES)
        begin
            w.entry_valid = 1;
            if (sel < ITEMS)
                v = 64'(total_cnt[sel]);
        end
        w.read_data = v[47:0];
        w.entry_count = hosts_used[5:0];
        return w;
    endfunction

    // one word on the input channel, predicted when it is accepted
    task automatic send_word(bit cmd, logic [7:0] b, logic last, logic [6:0] idx,
                             logic [5:0] sel);
        if (burst_mode && $urandom_range(0, 5) == 0)
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        items.valid       <= 1'b1;
        items.command     <= cmd;
        items.frame_byte  <= b;
        items.frame_last  <= last;
        items.entry_index <= idx;
        items.item_select <= sel;
        do
            @(posedge clk);
        while (!items.ready);
        if (cmd == CMD_READ)
            expected_reads.push_back(predict_read(idx, sel));
        else
            predict_byte(b, last);
    endtask

    task automatic read_item(int idx, int sel);
        send_word(CMD_READ, 8'($urandom), 1'($urandom), idx[6:0], sel[5:0]);
    endtask

    task automatic send_frame(logic [47:0] dst, logic [47:0] src, logic [15:0] etype,
                              logic [7:0] proto, logic [15:0] sp, logic [15:0] dp,
                              int len, logic [3:0] ihl);
        logic [7:0] fb [];
        int start;
        fb = new[len];
        for (int i = 0; i < len; i++)
            fb[i] = 8'($urandom);
        for (int i = 0; i < 6; i++)
        begin
            if (i < len) fb[i] = dst[47 - 8 * i -: 8];
            if (i + 6 < len) fb[i + 6] = src[47 - 8 * i -: 8];
        end
        if (len > 12) fb[12] = etype[15:8];
        if (len > 13) fb[13] = etype[7:0];
        if (len > 14) fb[14] = {4'h4, ihl};
        if (len > 23) fb[23] = proto;
        start = 14 + 4 * ihl;
        if (start + 3 < len)
        begin
            fb[start] = sp[15:8]; fb[start + 1] = sp[7:0];
            fb[start + 2] = dp[15:8]; fb[start + 3] = dp[7:0];
        end
        for (int i = 0; i < len; i++)
            send_word(CMD_BYTE, fb[i], i == len - 1, 7'($urandom), 6'($urandom));
    endtask

    function automatic logic [47:0] pick_mac();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return BCAST_MAC;
        if (k < 7 && hosts_used > 0)
            return host_mac[$urandom_range(0, hosts_used - 1)];
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [15:0] pick_port();
        logic [15:0] well_known [8] = '{16'd68, 16'd67, 16'd80, 16'd443, 16'd143,
                                        16'd25, 16'd22, 16'd69};
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        return well_known[$urandom_range(0, 7)];
    endfunction

    task automatic random_frame();
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        int len, k;
        k = $urandom_range(0, 19);
        etype = (k < 14) ? ETH_IPV4 : (k < 17) ? ETH_ARP : 16'($urandom);
        k = $urandom_range(0, 9);
        proto = (k < 4) ? PROTO_TCP : (k < 7) ? PROTO_UDP : (k == 7) ? PROTO_ICMP :
                (k == 8) ? PROTO_IGMP : 8'($urandom);
        ihl = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 140) : $urandom_range(38, 70);
        send_frame(pick_mac(), pick_mac(), etype, proto, pick_port(), pick_port(), len, ihl);
    endtask

    task automatic wait_drained();
        items.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reads.size() != 0);
    endtask

    // long receiver hold-off, counted in cycles here
    always
    begin
        @(hold_go);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // results side: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (hold_off)
            results.ready <= 1'b0;
        else
            results.ready <= ((cycles / 40) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected read word %h", results.read_data);
            end
            else
            begin
                read_word_t want;
                want = expected_reads.pop_front();
                if (want.read_data !== results.read_data
                    || want.entry_valid !== results.entry_valid
                    || want.entry_count !== results.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read mismatch: exp %h/%b/%0d got %h/%b/%0d",
                                 want.read_data, want.entry_valid, want.entry_count,
                                 results.read_data, results.entry_valid,
                                 results.entry_count);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed_frames();
        send_frame(48'h0200_0000_0001, 48'h0200_0000_0002, ETH_ARP, 0, 0, 0, 42, 5);
        send_frame(48'h0200_0000_0002, 48'h0200_0000_0001, ETH_IPV4, PROTO_ICMP, 0, 0, 60, 5);
        send_frame(48'h0200_0000_0003, 48'h0200_0000_0001, ETH_IPV4, PROTO_IGMP, 0, 0, 60, 5);
        send_frame(48'h0200_0000_0003, 48'h0200_0000_0002, ETH_IPV4, 8'hFF, 0, 0, 60, 5);
        send_frame(48'h0200_0000_0001, 48'h0200_0000_0003, ETH_IPV4, PROTO_TCP, 1234, 80, 60,
                   5);
        send_frame(48'h0200_0000_0001, 48'h0200_0000_0002, ETH_IPV4, PROTO_UDP, 68, 67, 60, 5);
        // short frame, odd ihl, unknown ethertype
        send_frame(48'h0200_0000_0009, 48'h0200_0000_0008, ETH_IPV4, PROTO_TCP, 1, 1, 13, 5);
        send_frame(48'h0200_0000_0001, 48'h0200_0000_0002, ETH_IPV4, PROTO_TCP, 9, 9, 40, 1);
        send_frame(48'h0200_0000_0001, 48'h0200_0000_0002, 16'h86DD, PROTO_TCP, 9, 9, 60, 5);
        // broadcast inserted, then credited to all; self-addressed frame
        send_frame(BCAST_MAC, 48'h0200_0000_0001, ETH_ARP, 0, 0, 0, 42, 5);
        send_frame(BCAST_MAC, 48'h0200_0000_0002, ETH_IPV4, PROTO_UDP, 22, 143, 60, 5);
        send_frame(48'hFFFF_0000_0000, 48'hFFFF_0000_0000, ETH_IPV4, PROTO_TCP, 22, 143,
                   130, 15);
        send_frame(48'h0200_0000_0002, 48'h0000_0000_0000, ETH_IPV4, PROTO_TCP, 443, 25, 60, 5);
        send_frame(48'h0200_0000_0002, 48'h0200_0000_0001, ETH_IPV4, PROTO_UDP, 69, 443, 60, 5);
    endtask

    task automatic test_directed_reads();
        for (int sel = 0; sel < 34; sel += 11)
            read_item(0, sel);
        read_item(ENTRIES, RX_BASE + CAT_ARP);
        read_item(ENTRIES, SEL_MAC);
        read_item(ENTRIES, SEL_IP);
        read_item(127, 5);
        read_item(hosts_used, 0);
        read_item(1, 63);
        read_item(2, SEL_IP);
        wait_drained();
    endtask

    task automatic random_read();
        int idx, sel;
        idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
              ($urandom_range(0, 3) == 0) ? ENTRIES :
              (hosts_used > 0 ? $urandom_range(0, hosts_used - 1) : ENTRIES);
        sel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 33);
        read_item(idx, sel);
    endtask

    task automatic test_random_traffic(int words);
        int start_cycles;
        start_cycles = 0;
        while (start_cycles < words)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                random_read();
                start_cycles++;
            end
            else
            begin
                random_frame();
                start_cycles += 30;
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        -> hold_go;
        burst_mode = 1'b0;
        for (int i = 0; i < 40; i++)
            random_read();
        burst_mode = 1'b1;
        wait_drained();
    endtask

    task automatic test_full_table();
        int guard;
        guard = 0;
        while (hosts_used < ENTRIES - 1 && guard < 200)
        begin
            send_frame(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), ETH_ARP, 0, 0, 0,
                       14, 5);
            guard++;
        end
        send_frame(48'h0A0A_0A0A_0A0A, 48'h0B0B_0B0B_0B0B, ETH_ARP, 0, 0, 0, 20, 5);
        for (int i = 0; i < 30; i++)
            random_read();
        read_item(ENTRIES - 1, SEL_MAC);
        wait_drained();
    endtask

    initial
    begin
        items.valid = 1'b0;
        items.command = 1'b0;
        items.frame_byte = '0;
        items.frame_last = 1'b0;
        items.entry_index = '0;
        items.item_select = '0;
        hosts_used = 0;
        clear_capture();
        for (int k = 0; k < ITEMS; k++)
            total_cnt[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_directed_reads();
        test_random_traffic(70);
        test_backpressure();
        test_random_traffic(70);
        test_full_table();
        test_random_traffic(60);
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_reads.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
